>>> rtl/pceq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pceq_pkg
// Shared types and constants for the paced coin event queue: beat payloads,
// configuration bundle, queue entry layout and controller states.
// ----------------------------------------------------------------------------
package pceq_pkg;

  // queue depth default and field widths
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned CYCLE_W         = 64;
  localparam int unsigned STICKY_W        = 32;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;

  // opcodes of an input beat
  localparam logic OP_COIN = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // result kinds
  localparam logic KIND_RELEASED = 1'b0;
  localparam logic KIND_DROPPED  = 1'b1;

  // register indexes (word index into the register map)
  localparam logic REG_STICKY = 1'b0;
  localparam logic REG_BYPASS = 1'b1;

  // input beat
  typedef struct packed {
    logic               opcode;
    logic               coin_pressed;
    logic               coin_which;
    logic [CYCLE_W-1:0] cycle_now;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic result_kind;
    logic out_pressed;
    logic out_which;
  } out_item_t;

  // configuration registers as seen by the controller
  typedef struct packed {
    logic [STICKY_W-1:0] sticky_interval;
    logic                bypass_queue;
  } cfg_t;

  // one queue entry
  typedef struct packed {
    logic [CYCLE_W-1:0] due_cycle;
    logic               pressed;
    logic               which;
  } entry_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/paced_coin_event_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// paced_coin_event_queue_core
// Coin switch event pacing queue with APB-style configuration port.
// ----------------------------------------------------------------------------
// Works on one beat at a time. A queued coin event is written into the queue
// and the block is ready again on the next cycle. A poll on a non-empty queue
// makes a registered read of the head entry, then compares it in the check
// step: a head not yet due returns to idle, a released one goes on to the emit
// step, which moves the result into the output register. A bypassed or dropped
// coin event goes straight to the emit step. A poll on an empty queue ends in
// idle. The result sits in an output register, so the next beat is taken while
// it waits; a further result waits in the emit step until the output register
// frees. The queue storage has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module paced_coin_event_queue_core #(
  parameter int unsigned QUEUE_DEPTH = pceq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pceq_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pceq_pkg::out_item_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pceq_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pceq_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pceq_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  pceq_pkg::cfg_t   cfg;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  pceq_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  pceq_pkg::entry_t mem_rdata;

  // configuration registers
  pceq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // queue storage
  pceq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // controller
  pceq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
`default_nettype wire

>>> rtl/pceq_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pceq_cfg
// APB-style register file holding the sticky interval and the bypass flag.
// ----------------------------------------------------------------------------
module pceq_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pceq_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [pceq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [pceq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output pceq_pkg::cfg_t                           cfg
);

  logic [pceq_pkg::STICKY_W-1:0] sticky_r, sticky_nxt;
  logic                          bypass_r, bypass_nxt;
  logic                          wr_en;
  logic                          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pceq_pkg::APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  // register write decode
  always_comb begin
    sticky_nxt = sticky_r;
    bypass_nxt = bypass_r;
    if (wr_en) begin
      case (reg_idx)
        pceq_pkg::REG_STICKY: sticky_nxt = pwdata[pceq_pkg::STICKY_W-1:0];
        pceq_pkg::REG_BYPASS: bypass_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sticky_r <= '0;
      bypass_r <= 1'b0;
    end else begin
      sticky_r <= sticky_nxt;
      bypass_r <= bypass_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      pceq_pkg::REG_STICKY: prdata = sticky_r;
      pceq_pkg::REG_BYPASS: prdata = {{(pceq_pkg::APB_DATA_W-1){1'b0}}, bypass_r};
      default:              prdata = '0;
    endcase
  end

  assign cfg.sticky_interval = sticky_r;
  assign cfg.bypass_queue    = bypass_r;

endmodule
`default_nettype wire

>>> rtl/pceq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pceq_store
// Event queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pceq_store #(
  parameter int unsigned QUEUE_DEPTH = pceq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [PTR_W-1:0]      waddr,
  input  wire pceq_pkg::entry_t      wdata,
  input  wire logic                  re,
  input  wire logic [PTR_W-1:0]      raddr,
  output pceq_pkg::entry_t           rdata
);

  pceq_pkg::entry_t mem [QUEUE_DEPTH];
  pceq_pkg::entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/pceq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pceq_ctrl
// Queue controller: slot pacing, pointers and fill count, head due check
// against the poll cycle count, and the result output register.
// ----------------------------------------------------------------------------
module pceq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = pceq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pceq_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pceq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pceq_pkg::out_item_t      out_data,
  output logic                     mem_we,
  output logic [PTR_W-1:0]         mem_waddr,
  output pceq_pkg::entry_t         mem_wdata,
  output logic                     mem_re,
  output logic [PTR_W-1:0]         mem_raddr,
  input  wire pceq_pkg::entry_t    mem_rdata
);

  localparam int unsigned CW = pceq_pkg::CYCLE_W;

  pceq_pkg::state_t    state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]       last_r, last_nxt;
  logic [CW-1:0]       now_r, now_nxt;
  pceq_pkg::out_item_t pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  pceq_pkg::out_item_t out_data_r, out_data_nxt;

  logic                accept;
  logic                is_coin;
  logic                full;
  logic                empty;
  logic                out_free;
  logic                due_passed;
  logic [CW-1:0]       slot_base;
  logic [CW:0]         slot_sum;
  logic [CW-1:0]       slot;
  logic [PTR_W-1:0]    head_inc;
  logic [PTR_W-1:0]    tail_inc;

  assign accept     = in_valid && in_ready;
  assign is_coin    = (in_data.opcode == pceq_pkg::OP_COIN);
  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty      = (cnt_r == '0);
  assign out_free   = !out_valid_r || out_ready;
  assign due_passed = (now_r > mem_rdata.due_cycle);

  // pointer wrap for any depth
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  // slot pacing: raise to now, then add interval with saturation
  assign slot_base = (last_r < in_data.cycle_now) ? in_data.cycle_now : last_r;
  assign slot_sum  = {1'b0, slot_base} + {{(CW + 1 - pceq_pkg::STICKY_W){1'b0}},
                                          cfg.sticky_interval};
  assign slot      = slot_sum[CW] ? {CW{1'b1}} : slot_sum[CW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pceq_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_coin) begin
            if (cfg.bypass_queue || full) begin
              state_nxt = pceq_pkg::ST_EMIT;
            end
          end else if (!empty) begin
            state_nxt = pceq_pkg::ST_CHECK;
          end
        end
      end
      pceq_pkg::ST_CHECK: begin
        state_nxt = due_passed ? pceq_pkg::ST_EMIT : pceq_pkg::ST_IDLE;
      end
      pceq_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = pceq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pceq_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = tail_r;
    mem_raddr     = head_r;
    mem_wdata     = '{due_cycle: slot, pressed: in_data.coin_pressed,
                      which: in_data.coin_which};
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    now_nxt       = now_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      pceq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (is_coin) begin
            if (cfg.bypass_queue) begin
              pend_nxt = '{result_kind: pceq_pkg::KIND_RELEASED,
                           out_pressed: in_data.coin_pressed,
                           out_which:   in_data.coin_which};
            end else if (full) begin
              pend_nxt = '{result_kind: pceq_pkg::KIND_DROPPED,
                           out_pressed: in_data.coin_pressed,
                           out_which:   in_data.coin_which};
            end else begin
              mem_we   = 1'b1;
              tail_nxt = tail_inc;
              cnt_nxt  = cnt_r + 1'b1;
              last_nxt = slot;
            end
          end else if (!empty) begin
            mem_re  = 1'b1;
            now_nxt = in_data.cycle_now;
          end
        end
      end
      pceq_pkg::ST_CHECK: begin
        if (due_passed) begin
          pend_nxt = '{result_kind: pceq_pkg::KIND_RELEASED,
                       out_pressed: mem_rdata.pressed,
                       out_which:   mem_rdata.which};
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      pceq_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pceq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // fill count never goes past the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count exceeds depth");

  // empty or full queue has meeting pointers
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (head_r == tail_r))
    else $error("head and tail disagree with fill count");

  // an accepted enqueue grows the queue by one
  a_enq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_coin && !cfg.bypass_queue && !full) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("enqueue did not bump fill count");

  // a due head is removed as it is released
  a_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pceq_pkg::ST_CHECK && due_passed)
      |=> (cnt_r == $past(cnt_r) - 1'b1) && (state_r == pceq_pkg::ST_EMIT))
    else $error("release did not pop the head");

  // memory is never read and written in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("queue read and write overlap");

endmodule
`default_nettype wire

>>> tb/sv/tb_paced_coin_event_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paced_coin_event_queue_core
// Self-checking bench for the paced coin event queue: a directed table of
// beats and register writes, then randomised phases over several pacing
// settings, every result beat checked against the table or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_paced_coin_event_queue_core;

  localparam int unsigned DEPTH       = pceq_pkg::QUEUE_DEPTH_DEF;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          IDLE_TAIL   = 8;
  localparam int          PHASE_BEATS = 110;
  localparam int          REPORT_MAX  = 10;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t           kind;
    pceq_pkg::in_item_t  beat;
    int                  reps;
    bit                  typed;
    bit                  typed_has;
    pceq_pkg::out_item_t typed_res;
    logic                reg_idx;
    logic [31:0]         value;
  } step_row_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  pceq_pkg::in_item_t  in_data    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  pceq_pkg::out_item_t out_data;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [pceq_pkg::APB_ADDR_W-1:0] paddr  = '0;
  logic [pceq_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [pceq_pkg::APB_DATA_W-1:0] prdata;
  logic                pready;

  // predictor state: pacing registers and the event queue
  logic [31:0] sticky      = '0;
  logic        bypass_mode = 1'b0;
  logic [63:0] q_due   [DEPTH];
  logic        q_press [DEPTH];
  logic        q_which [DEPTH];
  int          q_head  = 0;
  int          q_tail  = 0;
  int          q_count = 0;
  logic [63:0] last_slot = '0;

  pceq_pkg::out_item_t awaited_results[$];
  step_row_t   opening_rows[$];
  step_row_t   closing_rows[$];
  logic [63:0] time_now   = '0;
  int          burst_left = 0;
  int          fail_count = 0;
  int          hold_req   = 0;
  int          hold_left  = 0;
  int          rx_tick    = 0;
  int          rx_mode    = 0;
  int          quiet      = 0;

  paced_coin_event_queue_core #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pacing and queueing of one accepted beat, returns 1 when it yields a result
  function automatic bit pace_event(input pceq_pkg::in_item_t beat,
                                    output pceq_pkg::out_item_t res);
    logic [63:0] slot;
    res = '0;
    if (beat.opcode == pceq_pkg::OP_COIN) begin
      res.out_pressed = beat.coin_pressed;
      res.out_which   = beat.coin_which;
      if (bypass_mode) begin
        res.result_kind = pceq_pkg::KIND_RELEASED;
        return 1'b1;
      end
      if (q_count >= DEPTH) begin
        res.result_kind = pceq_pkg::KIND_DROPPED;
        return 1'b1;
      end
      slot = (last_slot < beat.cycle_now) ? beat.cycle_now : last_slot;
      // saturate rather than wrap
      if (slot > ~64'd0 - {32'd0, sticky}) slot = ~64'd0;
      else slot = slot + {32'd0, sticky};
      last_slot       = slot;
      q_due[q_tail]   = slot;
      q_press[q_tail] = beat.coin_pressed;
      q_which[q_tail] = beat.coin_which;
      q_tail          = (q_tail + 1) % DEPTH;
      q_count++;
      return 1'b0;
    end
    if (q_count == 0) return 1'b0;
    if (!(beat.cycle_now > q_due[q_head])) return 1'b0;
    res.result_kind = pceq_pkg::KIND_RELEASED;
    res.out_pressed = q_press[q_head];
    res.out_which   = q_which[q_head];
    q_head = (q_head + 1) % DEPTH;
    q_count--;
    return 1'b1;
  endfunction

  function automatic pceq_pkg::out_item_t coin_result(logic kind, logic p, logic w);
    pceq_pkg::out_item_t r;
    r.result_kind = kind;
    r.out_pressed = p;
    r.out_which   = w;
    return r;
  endfunction

  function automatic step_row_t beat_row(logic op, logic p, logic w, logic [63:0] now,
                                         int reps, bit typed, bit has,
                                         pceq_pkg::out_item_t res);
    step_row_t r;
    r.kind              = ROW_BEAT;
    r.beat.opcode       = op;
    r.beat.coin_pressed = p;
    r.beat.coin_which   = w;
    r.beat.cycle_now    = now;
    r.reps              = reps;
    r.typed             = typed;
    r.typed_has         = has;
    r.typed_res         = res;
    r.reg_idx           = pceq_pkg::REG_STICKY;
    r.value             = '0;
    return r;
  endfunction

  function automatic step_row_t cfg_row(logic idx, logic [31:0] value);
    step_row_t r;
    r         = beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, '0, 0, 1'b0, 1'b0, '0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.value   = value;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random beat around the running cycle count, which then moves on
  function automatic pceq_pkg::in_item_t draw_beat();
    pceq_pkg::in_item_t b;
    b.opcode       = ($urandom_range(0, 99) < 55) ? pceq_pkg::OP_COIN : pceq_pkg::OP_POLL;
    b.coin_pressed = 1'($urandom_range(0, 1));
    b.coin_which   = 1'($urandom_range(0, 1));
    b.cycle_now    = time_now;
    if (b.opcode == pceq_pkg::OP_COIN && $urandom_range(0, 7) == 0 && time_now > 64)
      b.cycle_now = time_now - 64'($urandom_range(1, 64));
    if (b.opcode == pceq_pkg::OP_POLL && $urandom_range(0, 11) == 0)
      b.cycle_now = rand64();
    if ($urandom_range(0, 3) == 0)
      time_now = time_now + rand64() % ({31'd0, sticky, 1'b0} + 64'd3);
    else
      time_now = time_now + 64'($urandom_range(0, 2));
    return b;
  endfunction

  // sender bursts with random gaps, some bursts back to back
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // offer one beat and hold it until taken, valid stays high afterwards
  task automatic issue_beat(input pceq_pkg::in_item_t beat, input bit typed,
                            input bit typed_has, input pceq_pkg::out_item_t typed_res);
    pceq_pkg::out_item_t res;
    bit                  has;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    has = pace_event(beat, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) awaited_results.push_back(res);
  endtask

  // stop offering, let every result drain and the block fall idle
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // setup and access phases, then psel drops before the next transfer
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == pceq_pkg::REG_STICKY) sticky = value;
    else bypass_mode = value[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_rows(input step_row_t rows[$]);
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(rows[i].reg_idx, rows[i].value);
      end else begin
        repeat (rows[i].reps) begin
          pace_sender();
          issue_beat(rows[i].beat, rows[i].typed, rows[i].typed_has, rows[i].typed_res);
        end
      end
    end
  endtask

  // release everything still queued with polls past the latest due time
  task automatic drain_queue();
    pceq_pkg::in_item_t b;
    while (q_count > 0) begin
      b           = '0;
      b.opcode    = pceq_pkg::OP_POLL;
      b.cycle_now = last_slot + 64'd1;
      pace_sender();
      issue_beat(b, 1'b0, 1'b0, '0);
    end
    if (time_now <= last_slot) time_now = last_slot + 64'd1;
  endtask

  // result beat checking and receiver stall pattern
  always @(posedge clk) begin : rx_side
    pceq_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result beat: kind %0b pressed %0b which %0b",
                   out_data.result_kind, out_data.out_pressed, out_data.out_which);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.result_kind !== want.result_kind ||
            out_data.out_pressed !== want.out_pressed ||
            out_data.out_which !== want.out_which) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result mismatch: expected kind %0b pressed %0b which %0b, got %0b %0b %0b",
                     want.result_kind, want.out_pressed, want.out_which,
                     out_data.result_kind, out_data.out_pressed, out_data.out_which);
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_tick % 16 < 8);
      endcase
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("paced_coin_event_queue_core test failed");
        $finish;
      end
    end
  end

  // directed tables
  initial begin
    // after reset: empty poll, zero interval pacing, due strictly passed
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, 64'd0, 1, 1'b1, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b1, 1'b0, 64'd0, 1, 1'b1, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, 64'd0, 1, 1'b1, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, 64'd1, 1, 1'b1, 1'b1,
                           coin_result(pceq_pkg::KIND_RELEASED, 1'b1, 1'b0)));
    // pacing with an interval, second event behind the last slot
    opening_rows.push_back(cfg_row(pceq_pkg::REG_STICKY, 32'd10));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b0, 1'b1, 64'd100, 1, 1'b1, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b1, 1'b1, 64'd50, 1, 1'b0, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, 64'd110, 1, 1'b0, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b1, 1'b1, 64'd111, 1, 1'b0, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b1, 64'd121, 1, 1'b0, 1'b0, '0));
    // bypass forwards coins without queueing them
    opening_rows.push_back(cfg_row(pceq_pkg::REG_BYPASS, 32'd1));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b1, 1'b0, 64'd200, 1, 1'b1, 1'b1,
                           coin_result(pceq_pkg::KIND_RELEASED, 1'b1, 1'b0)));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b0, 1'b1, 64'd0, 1, 1'b1, 1'b1,
                           coin_result(pceq_pkg::KIND_RELEASED, 1'b0, 1'b1)));
    // fill the queue, then drops, bypass still forwarding while full
    opening_rows.push_back(cfg_row(pceq_pkg::REG_BYPASS, 32'd0));
    opening_rows.push_back(cfg_row(pceq_pkg::REG_STICKY, 32'd0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b1, 1'b0, 64'd500, DEPTH, 1'b1, 1'b0,
                           '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b0, 1'b1, 64'd500, 1, 1'b1, 1'b1,
                           coin_result(pceq_pkg::KIND_DROPPED, 1'b0, 1'b1)));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b1, 1'b1, 64'd600, 1, 1'b1, 1'b1,
                           coin_result(pceq_pkg::KIND_DROPPED, 1'b1, 1'b1)));
    opening_rows.push_back(cfg_row(pceq_pkg::REG_BYPASS, 32'd1));
    opening_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b0, 1'b0, 64'd600, 1, 1'b1, 1'b1,
                           coin_result(pceq_pkg::KIND_RELEASED, 1'b0, 1'b0)));
    opening_rows.push_back(cfg_row(pceq_pkg::REG_BYPASS, 32'd0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, 64'd500, 1, 1'b1, 1'b0, '0));
    opening_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, 64'd501, 1, 1'b1, 1'b1,
                           coin_result(pceq_pkg::KIND_RELEASED, 1'b1, 1'b0)));

    // slot saturation jams the queue for good, so it comes last
    closing_rows.push_back(cfg_row(pceq_pkg::REG_STICKY, 32'hFFFF_FFFF));
    closing_rows.push_back(cfg_row(pceq_pkg::REG_BYPASS, 32'd0));
    closing_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 1,
                           1'b1, 1'b0, '0));
    closing_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1,
                           1'b1, 1'b0, '0));
    closing_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1,
                           1'b1, 1'b0, '0));
    closing_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b0, 1'b0, 64'd5, 1, 1'b1, 1'b0, '0));
    closing_rows.push_back(cfg_row(pceq_pkg::REG_BYPASS, 32'd1));
    closing_rows.push_back(beat_row(pceq_pkg::OP_COIN, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1,
                           1'b1, 1'b1, coin_result(pceq_pkg::KIND_RELEASED, 1'b1, 1'b1)));
    closing_rows.push_back(beat_row(pceq_pkg::OP_POLL, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1,
                           1'b1, 1'b0, '0));
  end

  // main sequence
  initial begin : stimulus
    logic [31:0]        ph_sticky;
    logic               ph_bypass;
    pceq_pkg::in_item_t b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_rows(opening_rows);
    drain_queue();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       begin ph_sticky = 32'd0;         ph_bypass = 1'b0; end
        1:       begin ph_sticky = 32'd3;         ph_bypass = 1'b0; end
        2:       begin ph_sticky = 32'd40;        ph_bypass = 1'b0; end
        3:       begin ph_sticky = 32'd17;        ph_bypass = 1'b1; end
        4:       begin ph_sticky = 32'd1000;      ph_bypass = 1'b0; end
        5:       begin ph_sticky = 32'hFFFF_FFFF; ph_bypass = 1'b0; end
        default: begin ph_sticky = 32'd2;         ph_bypass = 1'b0; end
      endcase
      settle();
      cfg_write(pceq_pkg::REG_STICKY, ph_sticky);
      cfg_write(pceq_pkg::REG_BYPASS, {31'd0, ph_bypass});
      // long receiver hold while bypassed coins keep coming: block backs up
      if (ph == 3) begin
        hold_req = 300;
        repeat (30) begin
          b              = '0;
          b.opcode       = pceq_pkg::OP_COIN;
          b.coin_pressed = 1'($urandom_range(0, 1));
          b.coin_which   = 1'($urandom_range(0, 1));
          b.cycle_now    = time_now;
          issue_beat(b, 1'b0, 1'b0, '0);
        end
      end
      repeat (PHASE_BEATS) begin
        pace_sender();
        issue_beat(draw_beat(), 1'b0, 1'b0, '0);
      end
      drain_queue();
    end

    settle();
    run_rows(closing_rows);
    settle();

    if (fail_count == 0 && awaited_results.size() == 0)
      $display("paced_coin_event_queue_core test passed");
    else
      $display("paced_coin_event_queue_core test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/pceq_pkg.sv
rtl/pceq_cfg.sv
rtl/pceq_store.sv
rtl/pceq_ctrl.sv
rtl/paced_coin_event_queue_core.sv
tb/sv/tb_paced_coin_event_queue_core.sv
